// ===== rtl/core/cah_pkg.sv =====
package cah_pkg;

    localparam int MAX_BINS    = 256;
    localparam int BIN_AW      = $clog2(MAX_BINS);
    localparam int BIN_W       = BIN_AW + 1;
    localparam int CLASS_SLOTS = 16;
    localparam int SLOT_AW     = $clog2(CLASS_SLOTS);
    localparam int SLOT_W      = SLOT_AW + 1;
    localparam int CMEM_AW     = SLOT_AW + BIN_AW;
    localparam int COUNT_W     = 32;
    localparam int LEVEL_W     = 16;
    localparam int TIME_W      = 31;
    localparam int CLASS_W     = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 31;
    localparam int S_DATA_W    = 80;
    localparam int M_DATA_W    = 192;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // request codes
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_SPARE = 2'd3;

    // result status codes
    localparam logic [2:0] ST_COUNTED = 3'd0;
    localparam logic [2:0] ST_TIME    = 3'd1;
    localparam logic [2:0] ST_LEVEL   = 3'd2;
    localparam logic [2:0] ST_NO_SLOT = 3'd3;
    localparam logic [2:0] ST_READ    = 3'd4;
    localparam logic [2:0] ST_CLEARED = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_FIRST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_LAST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT  = 3'd5;

    typedef enum logic [2:0] {
        CMD_ADD,
        CMD_REJ_TIME,
        CMD_REJ_LEVEL,
        CMD_READ,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [BIN_W-1:0]    bin;
        logic [CLASS_W-1:0]  cls;
        logic [SLOT_W-1:0]   rslot;
        logic [BIN_W-1:0]    rbin;
    } cmd_t;

    typedef struct packed {
        logic [TIME_W-1:0]   time_first;
        logic [TIME_W-1:0]   time_last;
        logic [LEVEL_W-1:0]  min_level;
        logic [LEVEL_W-1:0]  max_level;
        logic [LEVEL_W-1:0]  bin_width;
        logic [BIN_W-1:0]    bin_count;
    } cfg_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [BIN_W-1:0]    bin_index;
        logic [COUNT_W-1:0]  global_count;
        logic [SLOT_W-1:0]   class_slot;
        logic [COUNT_W-1:0]  class_count;
        logic [COUNT_W-1:0]  read_value;
        logic [CLASS_W-1:0]  read_class_id;
        logic                read_slot_valid;
        logic [BIN_W-1:0]    first_bin;
        logic [BIN_W-1:0]    last_bin;
        logic [BIN_W-1:0]    peak_bin;
        logic [COUNT_W-1:0]  peak_count;
    } res_t;

    function automatic logic [BIN_W-1:0] eff_bins(input logic [BIN_W-1:0] n);
        logic [BIN_W-1:0] r;
        r = n;
        if (n == '0)
            r = BIN_W'(1);
        else if (n > BIN_W'(MAX_BINS))
            r = BIN_W'(MAX_BINS);
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
    endfunction

endpackage

// ===== rtl/core/cah_front.sv =====
module cah_front
    import cah_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          req_type,
    input  logic [TIME_W-1:0]   spike_time,
    input  logic [LEVEL_W-1:0]  spike_level,
    input  logic [CLASS_W-1:0]  spike_label,
    input  logic [SLOT_W-1:0]   read_slot,
    input  logic [BIN_W-1:0]    read_bin,
    output logic                out_valid,
    input  logic                out_ready,
    output cmd_t                out_cmd
);

    localparam int CNT_W = $clog2(LEVEL_W);

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} state_t;

    state_t               state_reg;
    cmd_t                 cmd_reg;
    logic [LEVEL_W-1:0]   rem_reg;
    logic [LEVEL_W-1:0]   quo_reg;
    logic [CNT_W-1:0]     cnt_reg;

    logic                 time_bad;
    logic                 level_bad;
    logic [LEVEL_W:0]     offset;
    logic [LEVEL_W-1:0]   width_eff;
    logic [LEVEL_W:0]     trial;
    logic                 trial_ge;
    logic [LEVEL_W:0]     trial_sub;
    logic [LEVEL_W-1:0]   rem_next;
    logic [LEVEL_W-1:0]   quo_next;
    logic [LEVEL_W:0]     bin_raw;
    logic [BIN_W-1:0]     n_eff;
    logic [BIN_W-1:0]     bin_clamped;

    always_comb
    begin
        time_bad  = (spike_time < cfg.time_first) || (spike_time > cfg.time_last);
        level_bad = ($signed(spike_level) > $signed(cfg.max_level)) ||
                    ($signed(spike_level) < $signed(cfg.min_level));
        offset    = {spike_level[LEVEL_W-1], spike_level} -
                    {cfg.min_level[LEVEL_W-1], cfg.min_level};
        width_eff = (cfg.bin_width == '0) ? LEVEL_W'(1) : cfg.bin_width;

        // one restoring division step per cycle
        trial     = {rem_reg, quo_reg[LEVEL_W-1]};
        trial_ge  = trial >= {1'b0, width_eff};
        trial_sub = trial - {1'b0, width_eff};
        rem_next  = trial_ge ? trial_sub[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
        quo_next  = {quo_reg[LEVEL_W-2:0], trial_ge};

        bin_raw     = {1'b0, quo_reg} + (LEVEL_W+1)'(1);
        n_eff       = eff_bins(cfg.bin_count);
        bin_clamped = (bin_raw > (LEVEL_W+1)'(n_eff)) ? n_eff : bin_raw[BIN_W-1:0];

        out_cmd = cmd_reg;
        out_cmd.bin = (cmd_reg.kind == CMD_ADD) ? bin_clamped : '0;
    end

    assign in_ready  = (state_reg == F_IDLE);
    assign out_valid = (state_reg == F_PUSH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg.cls   <= spike_label;
                        cmd_reg.rslot <= read_slot;
                        cmd_reg.rbin  <= read_bin;
                        cmd_reg.bin   <= '0;
                        rem_reg       <= '0;
                        quo_reg       <= offset[LEVEL_W-1:0];
                        cnt_reg       <= '0;
                        state_reg     <= F_PUSH;
                        if (req_type == REQ_CLEAR)
                            cmd_reg.kind <= CMD_CLEAR;
                        else if (req_type != REQ_ADD)
                            cmd_reg.kind <= CMD_READ;
                        else if (time_bad)
                            cmd_reg.kind <= CMD_REJ_TIME;
                        else if (level_bad)
                            cmd_reg.kind <= CMD_REJ_LEVEL;
                        else
                        begin
                            cmd_reg.kind <= CMD_ADD;
                            state_reg    <= F_DIV;
                        end
                    end
                end
                F_DIV:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(LEVEL_W - 1))
                        state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (out_ready)
                        state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/cah_queue.sv =====
module cah_queue
    import cah_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  cmd_t  in_cmd,
    output logic  out_valid,
    input  logic  out_ready,
    output cmd_t  out_cmd
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    cmd_t              q_mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W:0]    count_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != (PTR_W+1)'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = q_mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= in_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + (PTR_W+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (PTR_W+1)'(1);
        end
    end

endmodule

// ===== rtl/core/cah_back.sv =====
module cah_back
    import cah_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [BIN_W-1:0]  n_bins,
    input  logic              bin_count_wr,
    input  logic              q_valid,
    output logic              q_ready,
    input  cmd_t              q_cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output res_t              out_res
);

    typedef enum logic [2:0] {
        B_IDLE, B_EXEC, B_ADD_UPD, B_ROWCLR, B_RD_CAP, B_LIM, B_SCAN, B_DONE
    } state_t;

    typedef enum logic [1:0] {M_HIT, M_ALLOC, M_NONE} mode_t;

    logic [COUNT_W-1:0]  gmem [MAX_BINS];
    logic [COUNT_W-1:0]  cmem [CLASS_SLOTS*MAX_BINS];

    state_t              state_reg;
    cmd_t                cmd_reg;
    res_t                res_reg;
    res_t                out_res_reg;
    logic                out_valid_reg;
    mode_t               mode_reg;
    logic [SLOT_AW-1:0]  slot_idx_reg;
    logic [BIN_AW-1:0]   clr_idx_reg;
    logic [BIN_AW-1:0]   scan_idx_reg;
    logic [MAX_BINS-1:0] gvalid_reg;
    logic [CLASS_SLOTS-1:0] slot_used_reg;
    logic [CLASS_W-1:0]  slot_ids_reg [CLASS_SLOTS];
    logic [BIN_W-1:0]    first_reg;
    logic [BIN_W-1:0]    last_reg;
    logic [BIN_W-1:0]    peak_bin_reg;
    logic [COUNT_W-1:0]  peak_cnt_reg;
    logic                scan_pending_reg;
    logic [COUNT_W-1:0]  g_rdata_reg;
    logic                g_rvalid_reg;
    logic [COUNT_W-1:0]  c_rdata_reg;

    logic [BIN_W-1:0]    bin_m1;
    logic [BIN_W-1:0]    rbin_m1;
    logic [SLOT_W-1:0]   rslot_m1;
    logic                hit_any;
    logic [SLOT_AW-1:0]  hit_idx;
    logic                free_any;
    logic [SLOT_AW-1:0]  free_idx;
    logic [BIN_AW-1:0]   g_raddr;
    logic [CMEM_AW-1:0]  c_raddr;
    logic                c_we;
    logic [CMEM_AW-1:0]  c_waddr;
    logic [COUNT_W-1:0]  c_wdata;
    logic [COUNT_W-1:0]  g_new;
    logic [COUNT_W-1:0]  c_new;
    logic [BIN_W-1:0]    sc_bin;
    logic [COUNT_W-1:0]  sc_cnt;
    logic                rd_in_range;
    res_t                done_res;

    always_comb
    begin
        bin_m1   = cmd_reg.bin - BIN_W'(1);
        rbin_m1  = cmd_reg.rbin - BIN_W'(1);
        rslot_m1 = cmd_reg.rslot - SLOT_W'(1);

        // lowest matching slot and lowest free slot
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = CLASS_SLOTS - 1; i >= 0; i--)
        begin
            if (slot_used_reg[i] && (slot_ids_reg[i] == cmd_reg.cls))
            begin
                hit_any = 1'b1;
                hit_idx = SLOT_AW'(i);
            end
            if (!slot_used_reg[i])
            begin
                free_any = 1'b1;
                free_idx = SLOT_AW'(i);
            end
        end

        sc_bin = {1'b0, scan_idx_reg} + BIN_W'(1);
        sc_cnt = g_rvalid_reg ? g_rdata_reg : '0;
        g_new  = sat_inc(g_rvalid_reg ? g_rdata_reg : '0);
        c_new  = sat_inc(c_rdata_reg);

        priority if (state_reg == B_SCAN)
            g_raddr = scan_idx_reg + BIN_AW'(1);
        else if (state_reg == B_LIM)
            g_raddr = '0;
        else if (cmd_reg.kind == CMD_ADD)
            g_raddr = bin_m1[BIN_AW-1:0];
        else
            g_raddr = rbin_m1[BIN_AW-1:0];

        c_raddr = (cmd_reg.kind == CMD_ADD) ? {hit_idx, bin_m1[BIN_AW-1:0]}
                                            : {rslot_m1[SLOT_AW-1:0], rbin_m1[BIN_AW-1:0]};

        // class row update, or the row sweep of a newly taken slot
        c_we    = 1'b0;
        c_waddr = {slot_idx_reg, bin_m1[BIN_AW-1:0]};
        c_wdata = c_new;
        if (state_reg == B_ADD_UPD && mode_reg == M_HIT)
            c_we = 1'b1;
        else if (state_reg == B_ROWCLR)
        begin
            c_we    = 1'b1;
            c_waddr = {slot_idx_reg, clr_idx_reg};
            c_wdata = (clr_idx_reg == bin_m1[BIN_AW-1:0]) ? COUNT_W'(1) : '0;
        end

        rd_in_range = (cmd_reg.rslot <= SLOT_W'(CLASS_SLOTS)) && (cmd_reg.rbin != '0) &&
                      (cmd_reg.rbin <= BIN_W'(MAX_BINS));

        done_res            = res_reg;
        done_res.first_bin  = first_reg;
        done_res.last_bin   = last_reg;
        done_res.peak_bin   = peak_bin_reg;
        done_res.peak_count = peak_cnt_reg;
    end

    assign q_ready   = (state_reg == B_IDLE);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_ff @(posedge clk)
    begin
        g_rdata_reg  <= gmem[g_raddr];
        g_rvalid_reg <= gvalid_reg[g_raddr];
        if (state_reg == B_ADD_UPD)
            gmem[bin_m1[BIN_AW-1:0]] <= g_new;
    end

    always_ff @(posedge clk)
    begin
        c_rdata_reg <= cmem[c_raddr];
        if (c_we)
            cmem[c_waddr] <= c_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            out_valid_reg    <= 1'b0;
            gvalid_reg       <= '0;
            slot_used_reg    <= '0;
            for (int i = 0; i < CLASS_SLOTS; i++)
                slot_ids_reg[i] <= '0;
            first_reg        <= '0;
            last_reg         <= '0;
            peak_bin_reg     <= '0;
            peak_cnt_reg     <= '0;
            scan_pending_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == B_DONE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            // a clear empties everything and a finished scan is current
            if (bin_count_wr)
                scan_pending_reg <= 1'b1;
            else if ((state_reg == B_EXEC && cmd_reg.kind == CMD_CLEAR) ||
                     (state_reg == B_SCAN && sc_bin == n_bins))
                scan_pending_reg <= 1'b0;

            unique case (state_reg)
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg   <= q_cmd;
                        res_reg   <= '0;
                        state_reg <= B_EXEC;
                    end
                end
                B_EXEC:
                begin
                    unique case (cmd_reg.kind)
                        CMD_REJ_TIME:
                        begin
                            res_reg.status <= ST_TIME;
                            state_reg      <= B_LIM;
                        end
                        CMD_REJ_LEVEL:
                        begin
                            res_reg.status <= ST_LEVEL;
                            state_reg      <= B_LIM;
                        end
                        CMD_CLEAR:
                        begin
                            res_reg.status   <= ST_CLEARED;
                            gvalid_reg       <= '0;
                            slot_used_reg    <= '0;
                            for (int i = 0; i < CLASS_SLOTS; i++)
                                slot_ids_reg[i] <= '0;
                            first_reg        <= '0;
                            last_reg         <= '0;
                            peak_bin_reg     <= '0;
                            peak_cnt_reg     <= '0;
                            state_reg        <= B_LIM;
                        end
                        CMD_READ:
                        begin
                            res_reg.status <= ST_READ;
                            state_reg      <= B_RD_CAP;
                        end
                        CMD_ADD:
                        begin
                            if (hit_any)
                            begin
                                mode_reg     <= M_HIT;
                                slot_idx_reg <= hit_idx;
                            end
                            else if (free_any)
                            begin
                                mode_reg                <= M_ALLOC;
                                slot_idx_reg            <= free_idx;
                                slot_used_reg[free_idx] <= 1'b1;
                                slot_ids_reg[free_idx]  <= cmd_reg.cls;
                            end
                            else
                                mode_reg <= M_NONE;
                            state_reg <= B_ADD_UPD;
                        end
                        default:
                        begin
                            state_reg <= B_LIM;
                        end
                    endcase
                end
                B_ADD_UPD:
                begin
                    gvalid_reg[bin_m1[BIN_AW-1:0]] <= 1'b1;
                    res_reg.bin_index    <= cmd_reg.bin;
                    res_reg.global_count <= g_new;
                    if (first_reg == '0 || cmd_reg.bin < first_reg)
                        first_reg <= cmd_reg.bin;
                    if (cmd_reg.bin > last_reg)
                        last_reg <= cmd_reg.bin;
                    if (g_new > peak_cnt_reg ||
                        (g_new == peak_cnt_reg && cmd_reg.bin < peak_bin_reg))
                    begin
                        peak_cnt_reg <= g_new;
                        peak_bin_reg <= cmd_reg.bin;
                    end
                    unique case (mode_reg)
                        M_HIT:
                        begin
                            res_reg.status      <= ST_COUNTED;
                            res_reg.class_slot  <= {1'b0, slot_idx_reg} + SLOT_W'(1);
                            res_reg.class_count <= c_new;
                            state_reg           <= B_LIM;
                        end
                        M_ALLOC:
                        begin
                            res_reg.status      <= ST_COUNTED;
                            res_reg.class_slot  <= {1'b0, slot_idx_reg} + SLOT_W'(1);
                            res_reg.class_count <= COUNT_W'(1);
                            clr_idx_reg         <= '0;
                            state_reg           <= B_ROWCLR;
                        end
                        default:
                        begin
                            res_reg.status <= ST_NO_SLOT;
                            state_reg      <= B_LIM;
                        end
                    endcase
                end
                B_ROWCLR:
                begin
                    clr_idx_reg <= clr_idx_reg + BIN_AW'(1);
                    if (clr_idx_reg == BIN_AW'(MAX_BINS - 1))
                        state_reg <= B_LIM;
                end
                B_RD_CAP:
                begin
                    if (rd_in_range)
                    begin
                        if (cmd_reg.rslot == '0)
                        begin
                            res_reg.read_value      <= g_rvalid_reg ? g_rdata_reg : '0;
                            res_reg.read_slot_valid <= 1'b1;
                        end
                        else if (slot_used_reg[rslot_m1[SLOT_AW-1:0]])
                        begin
                            res_reg.read_value      <= c_rdata_reg;
                            res_reg.read_class_id   <= slot_ids_reg[rslot_m1[SLOT_AW-1:0]];
                            res_reg.read_slot_valid <= 1'b1;
                        end
                    end
                    state_reg <= B_LIM;
                end
                B_LIM:
                begin
                    if (scan_pending_reg)
                    begin
                        first_reg    <= '0;
                        last_reg     <= '0;
                        peak_bin_reg <= '0;
                        peak_cnt_reg <= '0;
                        scan_idx_reg <= '0;
                        state_reg    <= B_SCAN;
                    end
                    else
                        state_reg <= B_DONE;
                end
                B_SCAN:
                begin
                    if (sc_cnt != '0)
                    begin
                        if (first_reg == '0)
                            first_reg <= sc_bin;
                        last_reg <= sc_bin;
                        if (sc_cnt > peak_cnt_reg)
                        begin
                            peak_cnt_reg <= sc_cnt;
                            peak_bin_reg <= sc_bin;
                        end
                    end
                    if (sc_bin == n_bins)
                        state_reg <= B_DONE;
                    else
                        scan_idx_reg <= scan_idx_reg + BIN_AW'(1);
                end
                B_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_res_reg <= done_res;
                        state_reg   <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_peak_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE && peak_cnt_reg != '0) |->
        (first_reg != '0 && first_reg <= peak_bin_reg && peak_bin_reg <= last_reg))
        else $error("peak bin outside first/last span");

    a_empty_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE && first_reg == '0) |->
        (last_reg == '0 && peak_cnt_reg == '0))
        else $error("empty histogram with nonzero limits");

    a_counted_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.status == ST_COUNTED) |->
        (out_res_reg.class_slot != '0 && out_res_reg.bin_index != '0))
        else $error("counted item without slot or bin");

    a_scan_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_SCAN) |-> scan_pending_reg)
        else $error("limit scan without pending request");
`endif

endmodule

// ===== rtl/core/classed_amplitude_histogram.sv =====
// channel   dir  handshake                    tuser              tdata
// s_axis    in   s_axis_tvalid/s_axis_tready  req_type           spike fields, read selectors
// m_axis    out  m_axis_tvalid/m_axis_tready  status             counts, read data, limits
// cfg       in   cfg_we (no wait)             -                  cfg_addr, cfg_wdata
//
// a spike add is taken by the front end and passes its one-bit-a-step bin divider,
// then runs the back end's memory sequence
// a class seen for the first time adds a sweep of its row in the class memory
// after a bin_count write the next non-clear item adds a global memory scan, one bin a cycle
// reject, read and clear items skip the divider; front and back overlap via a 2-item queue
// no clearing pass after reset: valid bits and slot flags reset at once
module classed_amplitude_histogram
    import cah_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // spike_time, spike_level, spike_label, read_slot, read_bin, zero pad
    input  logic [S_DATA_W-1:0]    s_axis_tdata,
    // req_type
    input  logic [1:0]             s_axis_tuser,
    // result items
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // bin_index, global_count, class_slot, class_count, read_value, read_class_id,
    // read_slot_valid, first_bin, last_bin, peak_bin, peak_count, zero pad
    output logic [M_DATA_W-1:0]    m_axis_tdata,
    // status
    output logic [2:0]             m_axis_tuser,
    // configuration writes
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int M_PAD = M_DATA_W - ($bits(res_t) - 3);

    cfg_t  cfg_reg;
    logic  bin_count_wr;
    logic  fq_valid;
    logic  fq_ready;
    cmd_t  fq_cmd;
    logic  qb_valid;
    logic  qb_ready;
    cmd_t  qb_cmd;
    res_t  res;

    // register file, reset to full time window and full level range
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_first <= '0;
            cfg_reg.time_last  <= '1;
            cfg_reg.min_level  <= {1'b1, {(LEVEL_W-1){1'b0}}};
            cfg_reg.max_level  <= {1'b0, {(LEVEL_W-1){1'b1}}};
            cfg_reg.bin_width  <= LEVEL_W'(256);
            cfg_reg.bin_count  <= BIN_W'(MAX_BINS);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_TIME_FIRST: cfg_reg.time_first <= cfg_wdata[TIME_W-1:0];
                CFG_TIME_LAST:  cfg_reg.time_last  <= cfg_wdata[TIME_W-1:0];
                CFG_MIN_LEVEL:  cfg_reg.min_level  <= cfg_wdata[LEVEL_W-1:0];
                CFG_MAX_LEVEL:  cfg_reg.max_level  <= cfg_wdata[LEVEL_W-1:0];
                CFG_BIN_WIDTH:  cfg_reg.bin_width  <= cfg_wdata[LEVEL_W-1:0];
                CFG_BIN_COUNT:  cfg_reg.bin_count  <= cfg_wdata[BIN_W-1:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // a new bin count invalidates the tracked first/last/peak bins
    assign bin_count_wr = cfg_we && (cfg_addr == CFG_BIN_COUNT);

    // front end: range checks and bin divider
    cah_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .req_type    (s_axis_tuser),
        .spike_time  (s_axis_tdata[30:0]),
        .spike_level (s_axis_tdata[46:31]),
        .spike_label (s_axis_tdata[62:47]),
        .read_slot   (s_axis_tdata[67:63]),
        .read_bin    (s_axis_tdata[76:68]),
        .out_valid   (fq_valid),
        .out_ready   (fq_ready),
        .out_cmd     (fq_cmd)
    );

    // decoupling queue between classification and memory work
    cah_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    // back end: histogram memories, class slots, limit tracking, result register
    cah_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .n_bins       (eff_bins(cfg_reg.bin_count)),
        .bin_count_wr (bin_count_wr),
        .q_valid      (qb_valid),
        .q_ready      (qb_ready),
        .q_cmd        (qb_cmd),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_res      (res)
    );

    assign m_axis_tuser = res.status;
    assign m_axis_tdata = {{M_PAD{1'b0}}, res.peak_count, res.peak_bin, res.last_bin,
                           res.first_bin, res.read_slot_valid, res.read_class_id,
                           res.read_value, res.class_count, res.class_slot,
                           res.global_count, res.bin_index};

endmodule

// ===== tb/classed_amplitude_histogram_tb.sv =====
`timescale 1ns / 1ps

module classed_amplitude_histogram_tb;
    import cah_pkg::*;

    // keeps its own copy of the histograms, the class slots and the registers,
    // and queues up the result each accepted item must produce
    class spike_hist_model;
        logic [COUNT_W-1:0] gbins [MAX_BINS];
        logic [COUNT_W-1:0] cbins [CLASS_SLOTS][MAX_BINS];
        logic [CLASS_W-1:0] slot_ids [CLASS_SLOTS];
        bit                 slot_taken [CLASS_SLOTS];
        logic [TIME_W-1:0]  t_first;
        logic [TIME_W-1:0]  t_last;
        logic [LEVEL_W-1:0] lvl_min;
        logic [LEVEL_W-1:0] lvl_max;
        logic [LEVEL_W-1:0] width_reg;
        logic [BIN_W-1:0]   count_reg;
        res_t               pending_results [$];
        int                 errors;

        function new();
            t_first   = '0;
            t_last    = '1;
            lvl_min   = 16'h8000;
            lvl_max   = 16'h7fff;
            width_reg = 16'd256;
            count_reg = 9'd256;
            errors    = 0;
            wipe();
        endfunction

        function void wipe();
            for (int s = 0; s < CLASS_SLOTS; s++)
            begin
                slot_ids[s]   = '0;
                slot_taken[s] = 0;
                for (int b = 0; b < MAX_BINS; b++)
                    cbins[s][b] = '0;
            end
            for (int b = 0; b < MAX_BINS; b++)
                gbins[b] = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_TIME_FIRST: t_first   = val[TIME_W-1:0];
                CFG_TIME_LAST:  t_last    = val[TIME_W-1:0];
                CFG_MIN_LEVEL:  lvl_min   = val[LEVEL_W-1:0];
                CFG_MAX_LEVEL:  lvl_max   = val[LEVEL_W-1:0];
                CFG_BIN_WIDTH:  width_reg = val[LEVEL_W-1:0];
                CFG_BIN_COUNT:  count_reg = val[BIN_W-1:0];
                default: ;
            endcase
        endfunction

        function int bins_in_use();
            int n;
            n = int'(count_reg);
            if (n == 0)
                n = 1;
            if (n > MAX_BINS)
                n = MAX_BINS;
            return n;
        endfunction

        function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] c);
            return (c == '1) ? c : c + 1'b1;
        endfunction

        function void note_item(logic [1:0] req, logic [S_DATA_W-1:0] d);
            res_t r;
            logic [TIME_W-1:0]  t;
            logic [CLASS_W-1:0] cls;
            int lv, lo, hi, w, bin, slot, rs, rb, n;
            r   = '0;
            t   = d[30:0];
            lv  = $signed(d[46:31]);
            cls = d[62:47];
            rs  = d[67:63];
            rb  = d[76:68];
            lo  = $signed(lvl_min);
            hi  = $signed(lvl_max);
            n   = bins_in_use();
            if (req == REQ_CLEAR)
            begin
                wipe();
                r.status = ST_CLEARED;
            end
            else if (req == REQ_ADD)
            begin
                if (t < t_first || t > t_last)
                    r.status = ST_TIME;
                else if (lv > hi || lv < lo)
                    r.status = ST_LEVEL;
                else
                begin
                    w   = (width_reg == 0) ? 1 : width_reg;
                    bin = (lv - lo) / w + 1;
                    if (bin > n)
                        bin = n;
                    gbins[bin-1]   = bump(gbins[bin-1]);
                    r.bin_index    = BIN_W'(bin);
                    r.global_count = gbins[bin-1];
                    slot = 0;
                    for (int s = 0; s < CLASS_SLOTS && slot == 0; s++)
                        if (slot_taken[s] && slot_ids[s] == cls)
                            slot = s + 1;
                    // first sight of a class takes the lowest free slot, row zeroed
                    for (int s = 0; s < CLASS_SLOTS && slot == 0; s++)
                        if (!slot_taken[s])
                        begin
                            slot_taken[s] = 1;
                            slot_ids[s]   = cls;
                            for (int b = 0; b < MAX_BINS; b++)
                                cbins[s][b] = '0;
                            slot = s + 1;
                        end
                    if (slot == 0)
                        r.status = ST_NO_SLOT;
                    else
                    begin
                        cbins[slot-1][bin-1] = bump(cbins[slot-1][bin-1]);
                        r.status      = ST_COUNTED;
                        r.class_slot  = SLOT_W'(slot);
                        r.class_count = cbins[slot-1][bin-1];
                    end
                end
            end
            else
            begin
                // read, and the spare request code behaves as a read too
                r.status = ST_READ;
                if (rs <= CLASS_SLOTS && rb >= 1 && rb <= MAX_BINS)
                begin
                    if (rs == 0)
                    begin
                        r.read_value      = gbins[rb-1];
                        r.read_slot_valid = 1'b1;
                    end
                    else
                    begin
                        r.read_value      = cbins[rs-1][rb-1];
                        r.read_class_id   = slot_ids[rs-1];
                        r.read_slot_valid = slot_taken[rs-1];
                    end
                end
            end
            // limits are rescanned over the bins in use after every item
            for (int b = 1; b <= n; b++)
            begin
                if (gbins[b-1] == 0)
                    continue;
                if (r.first_bin == 0)
                    r.first_bin = BIN_W'(b);
                r.last_bin = BIN_W'(b);
                if (gbins[b-1] > r.peak_count)
                begin
                    r.peak_count = gbins[b-1];
                    r.peak_bin   = BIN_W'(b);
                end
            end
            pending_results.push_back(r);
        endfunction

        function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                $error("%s: expected %0h, got %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check(logic [2:0] st, logic [M_DATA_W-1:0] d);
            res_t e;
            if (pending_results.size() == 0)
            begin
                $error("result item with no request outstanding");
                errors++;
                return;
            end
            e = pending_results.pop_front();
            cmp("status", e.status, st);
            cmp("bin_index", e.bin_index, d[8:0]);
            cmp("global_count", e.global_count, d[40:9]);
            cmp("class_slot", e.class_slot, d[45:41]);
            cmp("class_count", e.class_count, d[77:46]);
            cmp("read_value", e.read_value, d[109:78]);
            cmp("read_class_id", e.read_class_id, d[125:110]);
            cmp("read_slot_valid", e.read_slot_valid, d[126]);
            cmp("first_bin", e.first_bin, d[135:127]);
            cmp("last_bin", e.last_bin, d[144:136]);
            cmp("peak_bin", e.peak_bin, d[153:145]);
            cmp("peak_count", e.peak_count, d[185:154]);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic [2:0]            m_axis_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    spike_hist_model model = new();

    // idling profile of the current phase, in percent
    int send_idle_pct;
    int recv_stall_pct;
    // long receiver hold-off, counted down by the receiver process
    int hold_off_cycles;

    // small pool of class ids, more than there are slots, so slots run out
    logic [CLASS_W-1:0] class_pool [20];

    classed_amplitude_histogram u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit, far above the slowest correct run
    initial
    begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

    // receiver: ready changes on the falling edge
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready   <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result items are checked on the rising edge
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            model.check(m_axis_tuser, m_axis_tdata);
    end

    // offer one item, note it at the edge that takes it; returns at a falling edge
    task automatic send_item(logic [1:0] req, logic [TIME_W-1:0] t, logic [15:0] lv,
                             logic [15:0] cls, logic [4:0] rs, logic [8:0] rb);
        logic [S_DATA_W-1:0] d;
        bit taken;
        d = {3'b0, rb, rs, cls, lv, t};
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= req;
        taken = 0;
        while (!taken)
        begin
            @(posedge clk);
            taken = s_axis_tready;
            if (taken)
                model.note_item(req, d);
            @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (model.pending_results.size() != 0)
            @(negedge clk);
    endtask

    // register writes only with the block idle; a bin_count write triggers a rescan
    task automatic set_config(logic [30:0] tf, logic [30:0] tl, logic [15:0] mn,
                              logic [15:0] mx, logic [15:0] w, logic [8:0] n);
        logic [30:0] vals [6];
        vals = '{tf, tl, {15'b0, mn}, {15'b0, mx}, {15'b0, w}, {22'b0, n}};
        wait_drained();
        repeat (40) @(negedge clk);
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= CFG_IDX_W'(i);
            cfg_wdata <= vals[i];
            model.set_reg(CFG_IDX_W'(i), vals[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic add_spike(logic [30:0] t, logic [15:0] lv, logic [15:0] cls);
        send_item(REQ_ADD, t, lv, cls, 5'($urandom), 9'($urandom));
    endtask

    task automatic read_bin(logic [4:0] rs, logic [8:0] rb);
        send_item(REQ_READ, 31'($urandom), 16'($urandom), 16'($urandom), rs, rb);
    endtask

    // one random item shaped by the current window and level range
    task automatic random_item();
        int pick, lo, hi;
        logic [30:0] t;
        logic [15:0] lv, cls;
        logic [4:0]  rs;
        logic [8:0]  rb;
        pick = $urandom_range(99);
        lo   = $signed(model.lvl_min);
        hi   = $signed(model.lvl_max);
        if (pick < 72)
        begin
            if ($urandom_range(9) < 8 && model.t_first <= model.t_last)
                t = 31'($urandom_range(model.t_last, model.t_first));
            else
                t = 31'($urandom);
            if ($urandom_range(9) < 8 && lo <= hi)
                lv = 16'(lo + int'($urandom_range(hi - lo)));
            else
                lv = 16'($urandom);
            cls = ($urandom_range(9) == 0) ? 16'($urandom) : class_pool[$urandom_range(19)];
            add_spike(t, lv, cls);
        end
        else if (pick < 96)
        begin
            if ($urandom_range(9) == 0)
            begin
                rs = 5'($urandom);
                rb = 9'($urandom);
            end
            else
            begin
                rs = 5'($urandom_range(CLASS_SLOTS + 1));
                rb = 9'($urandom_range(model.bins_in_use(), 1));
            end
            send_item(($urandom_range(7) == 0) ? REQ_SPARE : REQ_READ,
                      31'($urandom), 16'($urandom), 16'($urandom), rs, rb);
        end
        else
            send_item(REQ_CLEAR, 31'($urandom), 16'($urandom), 16'($urandom),
                      5'($urandom), 9'($urandom));
    endtask

    task automatic random_phase(int items, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < items; i++)
            random_item();
    endtask

    initial
    begin
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = REQ_ADD;
        m_axis_tready   = 1'b0;
        cfg_we          = 1'b0;
        cfg_addr        = CFG_TIME_FIRST;
        cfg_wdata       = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        for (int i = 0; i < 20; i++)
            class_pool[i] = 16'(i * 3 - 7);
        class_pool[0] = 16'h8000;
        class_pool[1] = 16'h7fff;
        class_pool[2] = 16'h0000;
        class_pool[3] = 16'hffff;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset settings, field extremes, reads of every kind
        add_spike(31'd0, 16'h8000, 16'h8000);
        add_spike(31'h7fffffff, 16'h7fff, 16'h7fff);
        add_spike(31'd5, 16'h0000, 16'h8000);
        add_spike(31'd6, 16'h7fff, 16'h0000);
        read_bin(5'd0, 9'd1);
        read_bin(5'd0, 9'd256);
        read_bin(5'd1, 9'd1);
        read_bin(5'd16, 9'd256);
        read_bin(5'd5, 9'd128);           // slot never allocated
        read_bin(5'd17, 9'd1);            // slot out of range
        read_bin(5'd31, 9'd1);
        read_bin(5'd0, 9'd0);             // bin zero
        read_bin(5'd0, 9'd257);           // bin past the table
        read_bin(5'd0, 9'd511);
        send_item(REQ_SPARE, 31'd0, 16'd0, 16'd0, 5'd1, 9'd256);   // spare code reads
        // run the slots out: seventeen distinct classes
        for (int i = 0; i < 17; i++)
            add_spike(31'(i), 16'(i * 1000), 16'(100 + i));
        send_item(REQ_CLEAR, 31'd0, 16'd0, 16'd0, 5'd0, 9'd0);
        read_bin(5'd1, 9'd1);

        // narrow window, odd width, few bins; time and level rejects at both edges
        set_config(31'd1000, 31'd2000000, 16'hfc18, 16'd1000, 16'd37, 9'd50);
        add_spike(31'd999, 16'd0, 16'd1);
        add_spike(31'd2000001, 16'd0, 16'd1);
        add_spike(31'd1000, 16'hfc17, 16'd1);
        add_spike(31'd2000000, 16'd1001, 16'd1);
        add_spike(31'd1500, 16'd1000, 16'd1);     // clamps into the last bin
        random_phase(180, 0, 0);

        // inverted level limits reject every level
        set_config(31'd0, 31'h7fffffff, 16'd100, 16'hff9c, 16'd1, 9'd256);
        random_phase(60, 62, 0);

        // zero width acts as one, zero bins acts as one
        set_config(31'd0, 31'h7fffffff, 16'hff80, 16'd127, 16'd0, 9'd0);
        random_phase(180, 0, 62);

        // bin count past the table, widest bins
        set_config(31'd0, 31'h7fffffff, 16'h8000, 16'h7fff, 16'hffff, 9'd300);
        random_phase(120, 22, 22);

        // single-instant window at the top, all bin-count bits set
        set_config(31'h7fffffff, 31'h7fffffff, 16'h8000, 16'h7fff, 16'd1, 9'd511);
        random_phase(60, 0, 0);

        // back to defaults with a long receiver hold-off while items keep coming
        set_config(31'd0, 31'h7fffffff, 16'h8000, 16'h7fff, 16'd256, 9'd256);
        hold_off_cycles = 3000;
        random_phase(200, 0, 0);
        // sender pause until every outstanding result is back
        wait_drained();
        random_phase(150, 62, 62);

        set_config(31'd12345, 31'h40000000, 16'hf000, 16'h0fff, 16'd64, 9'd128);
        random_phase(150, 0, 0);

        wait_drained();
        repeat (400) @(negedge clk);
        if (model.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
